// ===== hw/rtl/fqe_pkg.sv =====
// fqe_pkg: command and status codes, widths and defaults for the queue with edit
// no dependencies
`timescale 1ns / 1ps

package fqe_pkg;

    localparam int WORD_W        = 32;
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 2;
    localparam int DEPTH_DEFAULT = 16;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [WORD_W-1:0]   t_word;

    localparam t_cmd CMD_ENQ   = 3'd0;
    localparam t_cmd CMD_DEQ   = 3'd1;
    localparam t_cmd CMD_PEEK  = 3'd2;
    localparam t_cmd CMD_EDIT  = 3'd3;
    localparam t_cmd CMD_CLEAR = 3'd4;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_EMPTY    = 2'd1;
    localparam t_status ST_FULL     = 2'd2;
    localparam t_status ST_NOTFOUND = 2'd3;

endpackage

// ===== hw/rtl/fifo_queue_with_edit.sv =====
// fifo_queue_with_edit: ring-buffer queue of 32-bit words with in-place edit
// depends on fqe_pkg
//
// channel   direction  tdata                            tuser
// s_axis    in         [31:0] value, [63:32] replacement [2:0] cmd
// m_axis    out        [31:0] data                      [1:0] status, [2] is_empty
//
// enqueue, clear and unknown commands, as well as any dequeue, peek or edit on
// an empty queue, load their result into the output register on acceptance
// dequeue and peek pass through S_READ for the registered read of the word store
// edit scans k entries from the head, k between 1 and the fill count,
// one entry per cycle through the single read port of the store
// reset clears state, pointers, fill count and output valid; the store itself is not cleared
// a finished result waits in the output register; a new item is taken when
// no item is in progress and that register is empty or being drained
`timescale 1ns / 1ps

module fifo_queue_with_edit #(
    parameter int DEPTH = fqe_pkg::DEPTH_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [2*fqe_pkg::WORD_W-1:0]   i_s_axis_tdata,  // value, replacement
    input  logic [fqe_pkg::CMD_W-1:0]      i_s_axis_tuser,  // cmd
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [fqe_pkg::WORD_W-1:0]     o_m_axis_tdata,  // data
    output logic [fqe_pkg::STATUS_W:0]     o_m_axis_tuser   // status, is_empty
);
    import fqe_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EDIT = 2'd2;

    function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] idx);
        return (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    logic [1:0]    r_state,  n_state;
    logic [AW-1:0] r_head,   n_head;
    logic [AW-1:0] r_tail,   n_tail;
    logic [CW-1:0] r_count,  n_count;
    logic [AW-1:0] r_idx,    n_idx;
    logic [CW-1:0] r_left,   n_left;
    logic          r_is_deq, n_is_deq;
    t_word         r_value,  n_value;
    t_word         r_repl,   n_repl;

    logic          r_out_valid;
    t_word         r_out_data,   n_out_data;
    t_status       r_out_status, n_out_status;
    logic          r_out_empty;
    logic          out_load;

    t_word         r_mem [DEPTH];
    t_word         r_rd_data;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_word         mem_wdata;
    logic [AW-1:0] mem_raddr;

    logic          accept;
    t_cmd          in_cmd;

    assign in_cmd          = i_s_axis_tuser;
    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = {r_out_empty, r_out_status};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_idx        = r_idx;
        n_left       = r_left;
        n_is_deq     = r_is_deq;
        n_value      = r_value;
        n_repl       = r_repl;
        n_out_data   = '0;
        n_out_status = ST_OK;
        out_load     = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = r_tail;
        mem_wdata    = i_s_axis_tdata[WORD_W-1:0];
        mem_raddr    = r_head;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_value = i_s_axis_tdata[WORD_W-1:0];
                    n_repl  = i_s_axis_tdata[2*WORD_W-1:WORD_W];
                    case (in_cmd)
                        CMD_ENQ: begin
                            out_load = 1'b1;
                            if (r_count == CW'(DEPTH)) begin
                                n_out_status = ST_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                n_tail  = wrap_next(r_tail);
                                n_count = r_count + 1'b1;
                            end
                        end
                        CMD_DEQ, CMD_PEEK: begin
                            if (r_count == '0) begin
                                out_load     = 1'b1;
                                n_out_status = ST_EMPTY;
                            end else begin
                                n_is_deq = (in_cmd == CMD_DEQ);
                                n_state  = S_READ;
                            end
                        end
                        CMD_EDIT: begin
                            if (r_count == '0) begin
                                out_load     = 1'b1;
                                n_out_status = ST_EMPTY;
                            end else begin
                                n_idx   = r_head;
                                n_left  = r_count;
                                n_state = S_EDIT;
                            end
                        end
                        CMD_CLEAR: begin
                            out_load = 1'b1;
                            n_head   = '0;
                            n_tail   = '0;
                            n_count  = '0;
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                out_load   = 1'b1;
                n_out_data = r_rd_data;
                n_state    = S_IDLE;
                if (r_is_deq) begin
                    n_head  = wrap_next(r_head);
                    n_count = r_count - 1'b1;
                end
            end
            S_EDIT: begin
                if (r_rd_data == r_value) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_idx;
                    mem_wdata = r_repl;
                    out_load  = 1'b1;
                    n_state   = S_IDLE;
                end else if (r_left == CW'(1)) begin
                    out_load     = 1'b1;
                    n_out_status = ST_NOTFOUND;
                    n_state      = S_IDLE;
                end else begin
                    n_idx     = wrap_next(r_idx);
                    mem_raddr = wrap_next(r_idx);
                    n_left    = r_left - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_left   <= n_left;
        r_is_deq <= n_is_deq;
        r_value  <= n_value;
        r_repl   <= n_repl;
        if (out_load) begin
            r_out_data   <= n_out_data;
            r_out_status <= n_out_status;
            r_out_empty  <= (n_count == '0);
        end
    end

endmodule

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for fifo_queue_with_edit, directed rows then random command mix
// depends on fqe_pkg and fifo_queue_with_edit; results checked against the model or typed rows
`timescale 1ns / 1ps

module tb_top;
    import fqe_pkg::*;

    localparam int          DEPTH        = DEPTH_DEFAULT;
    localparam int          RANDOM_ITEMS = 1200;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 40;

    typedef struct {
        t_cmd    cmd;
        t_word   value;
        t_word   replacement;
        bit      typed;
        t_word   want_data;
        t_status want_status;
        bit      want_empty;
    } t_queue_req;

    typedef struct {
        t_word   data;
        t_status status;
        bit      is_empty;
    } t_queue_resp;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    s_valid;
    logic                    s_ready;
    logic                    m_valid;
    logic                    m_ready;
    logic [WORD_W-1:0]       m_data;
    logic [STATUS_W:0]       m_user;
    t_queue_req              drv_item;

    // model of the queue contents
    t_word                   model_words [DEPTH];
    int unsigned             model_head;
    int unsigned             model_tail;
    int unsigned             model_fill;

    t_queue_resp             pending_results [$];
    t_queue_req              directed_rows [$];
    t_word                   recent_words [$];

    int unsigned             err_count;
    int unsigned             items_accepted;
    int unsigned             results_seen;
    int unsigned             cycle_count;
    int unsigned             cmd_count [8];
    int unsigned             full_hits;
    int unsigned             empty_hits;
    int unsigned             miss_hits;

    fifo_queue_with_edit #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  ({drv_item.replacement, drv_item.value}),  // value, replacement
        .i_s_axis_tuser  (drv_item.cmd),                            // cmd
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),                                  // data
        .o_m_axis_tuser  (m_user)                                   // status, is_empty
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_queue_resp queue_apply(input t_cmd cmd, input t_word value,
                                                input t_word repl);
        t_queue_resp resp;
        int unsigned idx;
        bit          hit;
        resp.data   = '0;
        resp.status = ST_OK;
        case (cmd)
            CMD_ENQ: begin
                if (model_fill == DEPTH) begin
                    resp.status = ST_FULL;
                end else begin
                    model_words[model_tail] = value;
                    model_tail = (model_tail + 1) % DEPTH;
                    model_fill++;
                end
            end
            CMD_DEQ, CMD_PEEK: begin
                if (model_fill == 0) begin
                    resp.status = ST_EMPTY;
                end else begin
                    resp.data = model_words[model_head];
                    if (cmd == CMD_DEQ) begin
                        model_head = (model_head + 1) % DEPTH;
                        model_fill--;
                    end
                end
            end
            CMD_EDIT: begin
                if (model_fill == 0) begin
                    resp.status = ST_EMPTY;
                end else begin
                    idx = model_head;
                    hit = 1'b0;
                    for (int i = 0; i < model_fill && !hit; i++) begin
                        if (model_words[idx] == value) begin
                            model_words[idx] = repl;
                            hit = 1'b1;
                        end
                        idx = (idx + 1) % DEPTH;
                    end
                    if (!hit) resp.status = ST_NOTFOUND;
                end
            end
            CMD_CLEAR: begin
                model_head = 0;
                model_tail = 0;
                model_fill = 0;
            end
            default: ;
        endcase
        resp.is_empty = (model_fill == 0);
        return resp;
    endfunction

    // item acceptance and result checking
    always @(posedge i_clk) begin : monitor
        t_queue_resp exp_r;
        t_queue_resp got;
        if (i_rst_n) begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (pending_results.size() == 0) begin
                    $error("result with nothing outstanding: data %h tuser %b", m_data, m_user);
                    err_count++;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (m_data !== exp_r.data) begin
                        $error("data: expected %h, actual %h", exp_r.data, m_data);
                        err_count++;
                    end
                    if (m_user[STATUS_W-1:0] !== exp_r.status) begin
                        $error("status: expected %0d, actual %0d", exp_r.status,
                               m_user[STATUS_W-1:0]);
                        err_count++;
                    end
                    if (m_user[STATUS_W] !== exp_r.is_empty) begin
                        $error("is_empty: expected %0d, actual %0d", exp_r.is_empty,
                               m_user[STATUS_W]);
                        err_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                items_accepted <= items_accepted + 1;
                cmd_count[drv_item.cmd]++;
                got = queue_apply(drv_item.cmd, drv_item.value, drv_item.replacement);
                if (drv_item.typed) begin
                    got.data     = drv_item.want_data;
                    got.status   = drv_item.want_status;
                    got.is_empty = drv_item.want_empty;
                end
                case (got.status)
                    ST_FULL:     full_hits++;
                    ST_EMPTY:    empty_hits++;
                    ST_NOTFOUND: miss_hits++;
                    default: ;
                endcase
                pending_results.push_back(got);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off, one stretch with none
    initial begin : receiver
        bit held;
        held    = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && results_seen >= 250) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (200) @(posedge i_clk);
            end else if (results_seen >= 600 && results_seen < 800) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 22);
            end
        end
    end

    task automatic add_row(input t_cmd cmd, input t_word value, input t_word repl,
                           input bit typed, input t_word want_data,
                           input t_status want_status, input bit want_empty);
        t_queue_req row;
        row.cmd         = cmd;
        row.value       = value;
        row.replacement = repl;
        row.typed       = typed;
        row.want_data   = want_data;
        row.want_status = want_status;
        row.want_empty  = want_empty;
        directed_rows.push_back(row);
    endtask

    task automatic send_item(input t_queue_req item, input bit no_gaps);
        while (!no_gaps && $urandom_range(0, 99) < 22) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid  <= 1'b1;
        drv_item <= item;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
    endtask

    function automatic t_word pick_word(input int unsigned recent_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < recent_pct && recent_words.size() > 0)
            return recent_words[$urandom_range(0, recent_words.size() - 1)];
        r = $urandom_range(0, 99);
        if (r < 50) return t_word'($urandom);
        if (r < 80) return t_word'($urandom_range(0, 7));
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '1;
            default: return '0;
        endcase
    endfunction

    initial begin : driver
        t_queue_req  item;
        int unsigned enq_pct;
        int unsigned r;
        i_rst_n        = 1'b0;
        s_valid        = 1'b0;
        drv_item       = '{cmd: CMD_ENQ, value: '0, replacement: '0, typed: 1'b0,
                           want_data: '0, want_status: ST_OK, want_empty: 1'b0};
        err_count      = 0;
        items_accepted = 0;
        results_seen   = 0;
        cycle_count    = 0;
        full_hits      = 0;
        empty_hits     = 0;
        miss_hits      = 0;
        model_head     = 0;
        model_tail     = 0;
        model_fill     = 0;
        enq_pct        = 50;
        foreach (cmd_count[k]) cmd_count[k] = 0;

        add_row(CMD_DEQ,   '0, '0, 1, '0, ST_EMPTY, 1);
        add_row(CMD_PEEK,  '0, '0, 1, '0, ST_EMPTY, 1);
        add_row(CMD_EDIT,  '0, '0, 1, '0, ST_EMPTY, 1);
        add_row(CMD_ENQ,   32'h8000_0000, '0, 1, '0, ST_OK, 0);
        add_row(CMD_ENQ,   32'h7fff_ffff, '0, 1, '0, ST_OK, 0);
        add_row(CMD_PEEK,  '0, '0, 1, 32'h8000_0000, ST_OK, 0);
        add_row(CMD_EDIT,  32'h7fff_ffff, 32'hffff_ffff, 1, '0, ST_OK, 0);
        add_row(CMD_EDIT,  32'h1234_5678, '0, 1, '0, ST_NOTFOUND, 0);
        add_row(t_cmd'(CMD_CLEAR + 3), 32'hffff_ffff, 32'hffff_ffff, 1, '0, ST_OK, 0);
        for (int i = 0; i < DEPTH - 2; i++)
            add_row(CMD_ENQ, 32'h5a5a_0000 + i, '0, 1, '0, ST_OK, 0);
        add_row(CMD_ENQ,   32'h0bad_cafe, '0, 1, '0, ST_FULL, 0);
        // match sits in the last slot, so the edit walks the whole store
        add_row(CMD_EDIT,  32'h5a5a_0000 + DEPTH - 3, 32'hdead_beef, 1, '0, ST_OK, 0);
        add_row(CMD_DEQ,   '0, '0, 0, '0, ST_OK, 0);
        add_row(CMD_PEEK,  '0, '0, 0, '0, ST_OK, 0);
        add_row(CMD_CLEAR, '0, '0, 1, '0, ST_OK, 1);
        add_row(CMD_ENQ,   32'h0000_0001, '0, 0, '0, ST_OK, 0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) send_item(directed_rows[k], 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // swing between filling and draining phases to hit full and empty
            if (n % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0: enq_pct = 75;
                    1: enq_pct = 45;
                    default: enq_pct = 20;
                endcase
            end
            item.typed       = 1'b0;
            item.want_data   = '0;
            item.want_status = ST_OK;
            item.want_empty  = 1'b0;
            item.value       = pick_word(20);
            item.replacement = pick_word(10);
            r = $urandom_range(0, 99);
            if (r < enq_pct) begin
                item.cmd = CMD_ENQ;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 45)      item.cmd = CMD_DEQ;
                else if (r < 60) item.cmd = CMD_PEEK;
                else if (r < 92) item.cmd = CMD_EDIT;
                else if (r < 96) item.cmd = CMD_CLEAR;
                else             item.cmd = t_cmd'(CMD_CLEAR + $urandom_range(1, 3));
            end
            if (item.cmd == CMD_EDIT) item.value = pick_word(65);
            if (item.cmd == CMD_ENQ) begin
                recent_words.push_back(item.value);
                if (recent_words.size() > DEPTH) void'(recent_words.pop_front());
            end
            send_item(item, n >= 500 && n < 700);
        end
        s_valid <= 1'b0;

        @(posedge i_clk);
        while (results_seen != items_accepted) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            err_count++;
        end
        $display("covered %0d items: enq %0d, deq %0d, peek %0d, edit %0d, clear %0d, other %0d",
                 items_accepted, cmd_count[CMD_ENQ], cmd_count[CMD_DEQ], cmd_count[CMD_PEEK],
                 cmd_count[CMD_EDIT], cmd_count[CMD_CLEAR],
                 cmd_count[5] + cmd_count[6] + cmd_count[7]);
        $display("results checked %0d: full %0d, empty %0d, edit misses %0d",
                 results_seen, full_hits, empty_hits, miss_hits);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== fifo_queue_with_edit.f =====
hw/rtl/fqe_pkg.sv
hw/rtl/fifo_queue_with_edit.sv
test/tb_top.sv
